### design/multi_axis_velocity_controller_unit_macros.svh
// Assertion helpers for the controller files, used by mavc_ctrl.
`ifndef MULTI_AXIS_VELOCITY_CONTROLLER_UNIT_MACROS_SVH
`define MULTI_AXIS_VELOCITY_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MAVC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MAVC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/mavc_pkg.sv
package mavc_pkg;

	localparam int AXIS_W     = 3;
	localparam int POS_W      = 32;
	localparam int DT_W       = 16;
	localparam int GAIN_W     = 24;
	localparam int NUM_GAINS  = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int ERR_W      = POS_W + 1;
	localparam int PROD_W     = ERR_W + GAIN_W;
	localparam int FRAC_W     = 16;
	localparam int SHIFT_W    = PROD_W - FRAC_W;
	localparam int SUM_W      = SHIFT_W + 1;

	localparam logic [1:0] OP_UPDATE    = 2'd0;
	localparam logic [1:0] OP_RESET_ALL = 2'd1;
	localparam logic [1:0] OP_RESET_ONE = 2'd2;
	localparam logic [1:0] OP_STOP      = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_AXES = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_BASE   = 3'd1;

	localparam logic [AXIS_W-1:0]        ACTIVE_RESET = 3'd6;
	localparam logic signed [GAIN_W-1:0] GAIN_RESET   = 24'sd65536;

	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);
	localparam logic signed [SUM_W-1:0]  SUM_MAX    = SUM_W'(64'sd2147483647);
	localparam logic signed [SUM_W-1:0]  SUM_MIN    = SUM_W'(-64'sd2147483648);
	localparam logic signed [POS_W-1:0]  VAL_MAX    = 32'sh7FFF_FFFF;
	localparam logic signed [POS_W-1:0]  VAL_MIN    = 32'sh8000_0000;

	typedef logic signed [GAIN_W-1:0] gain_t;
	typedef gain_t [NUM_GAINS-1:0] gain_arr_t;

	typedef struct packed {
		logic [1:0]              opcode;
		logic [AXIS_W-1:0]       axis;
		logic signed [POS_W-1:0] measured_position;
		logic signed [POS_W-1:0] desired_velocity;
		logic [DT_W-1:0]         elapsed_time;
	} item_t;

	typedef struct packed {
		logic [AXIS_W-1:0]       out_axis;
		logic signed [POS_W-1:0] velocity_command;
		logic                    saturated;
	} result_t;

	typedef struct packed {
		logic latch;
		logic mul1;
		logic add1;
		logic mul2;
		logic fin;
		logic clr_all;
		logic clr_one;
		logic stop;
	} cmd_t;

endpackage

### design/mavc_cfg.sv
module mavc_cfg import mavc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [AXIS_W-1:0]     active_axes,
	output gain_arr_t             gain
);

	logic [AXIS_W-1:0] active_axes_q;
	gain_arr_t         gain_q;

	assign cfg_ready   = 1'b1;
	assign active_axes = active_axes_q;
	assign gain        = gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_axes_q <= ACTIVE_RESET;
			for (int i = 0; i < NUM_GAINS; i++) begin
				gain_q[i] <= GAIN_RESET;
			end
		end else if (cfg_valid) begin
			if (cfg_index == CFG_ACTIVE_AXES) begin
				active_axes_q <= cfg_data[AXIS_W-1:0];
			end
			for (int i = 0; i < NUM_GAINS; i++) begin
				if (cfg_index == CFG_IDX_W'(int'(CFG_GAIN_BASE) + i)) begin
					gain_q[i] <= cfg_data[GAIN_W-1:0];
				end
			end
		end
	end

endmodule

### design/mavc_ctrl.sv
`include "multi_axis_velocity_controller_unit_macros.svh"

module mavc_ctrl import mavc_pkg::*; #(
	parameter int AXIS_COUNT = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_stall,
	input  logic [AXIS_W-1:0] active_axes,
	output cmd_t              cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL1 = 3'd1;
	localparam logic [2:0] S_ADD1 = 3'd2;
	localparam logic [2:0] S_MUL2 = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	localparam logic [AXIS_W-1:0] AXES_N = AXIS_W'(AXIS_COUNT);

	logic [2:0]        state_q, state_d;
	logic              out_valid_q;
	logic              out_free, in_ready, accept, fin_done, go_update;
	logic [AXIS_W-1:0] limit;

	assign out_free   = !out_valid_q || !result_stall;
	assign in_ready   = (state_q == S_IDLE) || (state_q == S_FIN && out_free);
	assign item_stall = !in_ready;
	assign accept     = item_valid && in_ready;
	assign fin_done   = (state_q == S_FIN) && out_free;
	assign limit      = (active_axes < AXES_N) ? active_axes : AXES_N;
	assign go_update  = accept && item.opcode == OP_UPDATE && item.axis < limit;

	assign result_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.latch   = go_update;
		cmd.mul1    = (state_q == S_MUL1);
		cmd.add1    = (state_q == S_ADD1);
		cmd.mul2    = (state_q == S_MUL2);
		cmd.fin     = fin_done;
		cmd.clr_all = accept && item.opcode == OP_RESET_ALL;
		cmd.clr_one = accept && item.opcode == OP_RESET_ONE && item.axis < AXES_N;
		cmd.stop    = accept && item.opcode == OP_STOP;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (go_update) state_d = S_MUL1;
			end
			S_MUL1: state_d = S_ADD1;
			S_ADD1: state_d = S_MUL2;
			S_MUL2: state_d = S_FIN;
			S_FIN: begin
				// hold until the output register frees up
				if (out_free) state_d = go_update ? S_MUL1 : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= fin_done || (out_valid_q && result_stall);
		end
	end

	`MAVC_ASSERT_IMP(a_accept_when_free, item_valid && !item_stall, state_q == S_IDLE || state_q == S_FIN, "word accepted mid-update")
	`MAVC_ASSERT_NXT(a_fin_gives_word, cmd.fin, result_valid, "finished update shows no word")
	`MAVC_ASSERT_NXT(a_mul1_then_add1, state_q == S_MUL1, state_q == S_ADD1, "sequence skipped a step")
	`MAVC_ASSERT_NXT(a_blocked_fin_holds, state_q == S_FIN && result_valid && result_stall, state_q == S_FIN && result_valid, "blocked result lost")

endmodule

### design/mavc_dp.sv
module mavc_dp import mavc_pkg::*; #(
	parameter int AXIS_COUNT = 6
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  item_t     item,
	input  gain_arr_t gain,
	output result_t   result
);

	localparam int IDX_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

	logic [AXIS_W-1:0]        axis_q;
	logic signed [POS_W-1:0]  pm_q, vd_q, base_q;
	logic [DT_W-1:0]          dt_q;
	logic [AXIS_COUNT-1:0]    init_q;
	logic signed [POS_W-1:0]  ip_q [AXIS_COUNT];
	logic signed [POS_W-1:0]  lv_q [AXIS_COUNT];
	logic signed [ERR_W-1:0]  err_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                     sat_q;
	result_t                  result_q;

	logic [IDX_W-1:0]          idx, clr_idx;
	logic signed [ERR_W-1:0]   mul_a;
	logic signed [GAIN_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]  mul_p, rnd;
	logic signed [SHIFT_W-1:0] shifted;
	logic signed [POS_W-1:0]   addend, sat_val;
	logic signed [SUM_W-1:0]   sum;
	logic                      sat_hi, sat_lo;

	assign idx     = axis_q[IDX_W-1:0];
	assign clr_idx = item.axis[IDX_W-1:0];
	assign result  = result_q;

	// one shared multiplier: velocity * time first, then gain * error
	always_comb begin
		if (cmd.mul2) begin
			mul_a = err_q;
			mul_b = gain[axis_q];
		end else begin
			mul_a = ERR_W'(lv_q[idx]);
			mul_b = init_q[idx] ? GAIN_W'({{(GAIN_W-DT_W){1'b0}}, dt_q}) : '0;
		end
	end

	assign mul_p = mul_a * mul_b;

	// round half up, then add base position or feedforward, then clip
	assign rnd     = prod_q + ROUND_HALF;
	assign shifted = rnd[PROD_W-1:FRAC_W];
	assign addend  = cmd.fin ? vd_q : base_q;
	assign sum     = SUM_W'(shifted) + SUM_W'(addend);
	assign sat_hi  = sum > SUM_MAX;
	assign sat_lo  = sum < SUM_MIN;

	always_comb begin
		priority if (sat_hi) sat_val = VAL_MAX;
		else if (sat_lo)     sat_val = VAL_MIN;
		else                 sat_val = sum[POS_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			axis_q <= item.axis;
			pm_q   <= item.measured_position;
			vd_q   <= item.desired_velocity;
			dt_q   <= item.elapsed_time;
		end
		if (cmd.mul1) begin
			prod_q <= mul_p;
			base_q <= init_q[idx] ? ip_q[idx] : pm_q;
		end
		if (cmd.add1) begin
			ip_q[idx] <= sat_val;
			err_q     <= ERR_W'(sat_val) - ERR_W'(pm_q);
			sat_q     <= sat_hi || sat_lo;
		end
		if (cmd.mul2) begin
			prod_q <= mul_p;
		end
		if (cmd.fin) begin
			result_q.out_axis         <= axis_q;
			result_q.velocity_command <= sat_val;
			result_q.saturated        <= sat_q || sat_hi || sat_lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0;
			for (int i = 0; i < AXIS_COUNT; i++) begin
				lv_q[i] <= '0;
			end
		end else begin
			if (cmd.clr_all) begin
				init_q <= '0;
			end else if (cmd.clr_one) begin
				init_q[clr_idx] <= 1'b0;
			end else if (cmd.add1) begin
				init_q[idx] <= 1'b1;
			end
			// stop overrides a write-back in the same cycle
			if (cmd.stop) begin
				for (int i = 0; i < AXIS_COUNT; i++) begin
					lv_q[i] <= '0;
				end
			end else if (cmd.fin) begin
				lv_q[idx] <= sat_val;
			end
		end
	end

endmodule

### design/multi_axis_velocity_controller_unit.sv
// Per-axis velocity controller: proportional position feedback plus velocity
// feedforward in Q16.16. An update word integrates the axis's last command over
// the elapsed time into a desired position, then returns gain * (desired -
// measured) + desired velocity, clipped to 32 bits. An update is accepted,
// then steps through MUL1, ADD1, MUL2 and FIN; its result word is loaded into
// the output register as FIN ends, when the next word can be accepted as well,
// so a new update overlaps only the last step of the one before. The single
// 33x24 multiplier is used once for the position step and once for the gain
// product. Reset-all, reset-one and stop words, and updates to inactive axes,
// return no word. A full output register that is held off stalls the block in
// its last step. Configuration writes are taken every cycle.
module multi_axis_velocity_controller_unit import mavc_pkg::*; #(
	parameter int AXIS_COUNT = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [AXIS_W-1:0] active_axes;
	gain_arr_t         gain;
	cmd_t              cmd;

	mavc_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.active_axes (active_axes),
		.gain        (gain)
	);

	mavc_ctrl #(.AXIS_COUNT(AXIS_COUNT)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.active_axes  (active_axes),
		.cmd          (cmd)
	);

	mavc_dp #(.AXIS_COUNT(AXIS_COUNT)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.gain   (gain),
		.result (result)
	);

endmodule

### tb/tb_multi_axis_velocity_controller_unit.sv
`timescale 1ns / 100ps

module tb_multi_axis_velocity_controller_unit;
	import mavc_pkg::*;

	localparam int AXES = 6;
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam logic [GAIN_W-1:0] GAIN_MOST_NEG = 24'h800000;
	localparam logic [GAIN_W-1:0] GAIN_MOST_POS = 24'h7FFFFF;
	localparam longint CMD_MAX = 64'sd2147483647;
	localparam longint CMD_MIN = -64'sd2147483648;

	class velocity_scoreboard;
		logic [2:0] active_axes;
		gain_t gains [NUM_GAINS];
		bit axis_ready [AXES];
		logic signed [POS_W-1:0] target_position [AXES];
		logic signed [POS_W-1:0] last_command [AXES];
		result_t pending_commands [$];
		int errors;

		function new();
			active_axes = ACTIVE_RESET;
			foreach (gains[i]) gains[i] = GAIN_RESET;
			foreach (axis_ready[i]) begin
				axis_ready[i] = 1'b0;
				target_position[i] = '0;
				last_command[i] = '0;
			end
			errors = 0;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 30) $display("%0t: %s", $time, msg);
		endtask

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_ACTIVE_AXES) begin
				active_axes = data[2:0];
			end else if (int'(idx) < int'(CFG_GAIN_BASE) + NUM_GAINS) begin
				gains[idx - CFG_GAIN_BASE] = data;
			end
		endfunction

		// round to nearest of x / 2^16, ties toward +inf
		function longint round_q16(longint x);
			return (x + 64'sd32768) >>> 16;
		endfunction

		function logic signed [POS_W-1:0] clip(longint x, inout bit flag);
			if (x > CMD_MAX) begin
				flag = 1'b1;
				return CMD_MAX[31:0];
			end
			if (x < CMD_MIN) begin
				flag = 1'b1;
				return CMD_MIN[31:0];
			end
			return x[31:0];
		endfunction

		function void note_item(item_t it);
			int lim;
			int a;
			longint dt;
			longint step;
			longint err;
			longint prod;
			bit clipped;
			result_t r;
			unique case (it.opcode)
				OP_RESET_ALL: begin
					foreach (axis_ready[i]) axis_ready[i] = 1'b0;
				end
				OP_RESET_ONE: begin
					if (it.axis < AXES) axis_ready[it.axis] = 1'b0;
				end
				OP_STOP: begin
					foreach (last_command[i]) last_command[i] = '0;
				end
				default: begin
					lim = (active_axes < AXES) ? active_axes : AXES;
					if (it.axis >= lim) return;
					a = it.axis;
					dt = longint'(it.elapsed_time);
					if (!axis_ready[a]) begin
						axis_ready[a] = 1'b1;
						target_position[a] = it.measured_position;
						dt = 0;
					end
					clipped = 1'b0;
					step = round_q16(longint'($signed(last_command[a])) * dt);
					target_position[a] = clip(longint'($signed(target_position[a])) + step,
						clipped);
					err = longint'($signed(target_position[a]))
						- longint'($signed(it.measured_position));
					prod = round_q16(longint'($signed(gains[a])) * err);
					last_command[a] = clip(prod + longint'($signed(it.desired_velocity)),
						clipped);
					r.out_axis = it.axis;
					r.velocity_command = last_command[a];
					r.saturated = clipped;
					pending_commands.push_back(r);
				end
			endcase
		endfunction

		task check_result(result_t got);
			result_t want;
			if (pending_commands.size() == 0) begin
				report($sformatf("velocity word for axis %0d with no update pending",
					got.out_axis));
				return;
			end
			want = pending_commands.pop_front();
			if (got.out_axis !== want.out_axis)
				report($sformatf("out_axis: got %0d, want %0d", got.out_axis, want.out_axis));
			if (got.velocity_command !== want.velocity_command)
				report($sformatf("axis %0d velocity_command: got %0d, want %0d",
					want.out_axis, $signed(got.velocity_command),
					$signed(want.velocity_command)));
			if (got.saturated !== want.saturated)
				report($sformatf("axis %0d saturated: got %b, want %b",
					want.out_axis, got.saturated, want.saturated));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	bit hold_results;

	velocity_scoreboard sb = new();

	multi_axis_velocity_controller_unit #(
		.AXIS_COUNT(AXES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic item_t make_item(logic [1:0] op, logic [2:0] ax, logic [31:0] pm,
		logic [31:0] vd, logic [15:0] dt);
		item_t it;
		it.opcode = op;
		it.axis = ax;
		it.measured_position = pm;
		it.desired_velocity = vd;
		it.elapsed_time = dt;
		return it;
	endfunction

	function automatic logic [GAIN_W-1:0] gain_in(int span);
		return GAIN_W'($urandom_range(0, 2 * span) - span);
	endfunction

	function automatic int next_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 10) return 0;
		if (r < 17) return $urandom_range(1, 3);
		if (r < 19) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic item_t rand_item();
		item_t it;
		int r;
		int lim;
		r = $urandom_range(0, 99);
		lim = (sb.active_axes < AXES) ? sb.active_axes : AXES;
		it = make_item(OP_UPDATE, 3'($urandom_range(0, 7)), $urandom, $urandom,
			16'($urandom_range(0, 65535)));
		if (r < 3) begin
			it.opcode = OP_RESET_ALL;
		end else if (r < 8) begin
			it.opcode = OP_RESET_ONE;
		end else if (r < 11) begin
			it.opcode = OP_STOP;
		end else if (r >= 26) begin
			// track a plausible trajectory, on an active axis when any is active
			it.axis = (lim > 0) ? 3'($urandom_range(0, lim - 1)) : 3'($urandom_range(0, 5));
			it.measured_position = $urandom_range(0, 1 << 23) - (1 << 22);
			it.desired_velocity = $urandom_range(0, 1 << 23) - (1 << 22);
			if ($urandom_range(0, 3) != 0) it.elapsed_time = 16'($urandom_range(0, 2048));
		end
		return it;
	endfunction

	task automatic send_item(item_t it, int gap);
		@(negedge clk);
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		sb.note_item(it);
		if (gap > 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic idle_input();
		@(negedge clk);
		item_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.pending_commands.size() != 0) @(posedge clk);
		// let a trailing word with no result finish
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(int p);
		logic [2:0] active;
		logic [GAIN_W-1:0] g;
		case (p)
			0: active = 3'd6;
			1: active = 3'd1;
			2: active = 3'd0;
			3: active = 3'd7;
			4: active = 3'd3;
			default: active = 3'd6;
		endcase
		write_reg(CFG_ACTIVE_AXES, CFG_DATA_W'(active));
		for (int i = 0; i < NUM_GAINS; i++) begin
			case (p)
				0: g = gain_in(262144);
				1: g = (i == 0) ? GAIN_MOST_NEG : GAIN_MOST_POS;
				2: g = '0;
				3: g = GAIN_W'($urandom);
				4: g = (i == 1) ? '0 : gain_in(131072);
				default: g = gain_in(65536);
			endcase
			write_reg(CFG_IDX_W'(CFG_GAIN_BASE + i), g);
		end
		if (p == 1) write_reg(CFG_UNUSED, 24'h00FFFF);
	endtask

	task automatic run_directed();
		send_item(make_item(OP_UPDATE, 3'd0, 32'h0001_2345, 32'h0001_0000, 16'hFFFF), 0);
		send_item(make_item(OP_UPDATE, 3'd0, 32'h0002_0000, 32'hFFFF_8000, 16'h8000), 1);
		send_item(make_item(OP_UPDATE, 3'd0, 32'h0000_0000, 32'h0000_0000, 16'h0000), 0);
		send_item(make_item(OP_UPDATE, 3'd5, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF), 0);
		send_item(make_item(OP_UPDATE, 3'd5, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF), 2);
		send_item(make_item(OP_UPDATE, 3'd4, 32'h8000_0000, 32'h8000_0000, 16'h0000), 0);
		send_item(make_item(OP_UPDATE, 3'd4, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF), 0);
		send_item(make_item(OP_UPDATE, 3'd6, 32'h0000_1000, 32'h0000_1000, 16'h0100), 0);
		send_item(make_item(OP_UPDATE, 3'd7, 32'h0000_1000, 32'h0000_1000, 16'h0100), 3);
		send_item(make_item(OP_RESET_ONE, 3'd0, 32'h0, 32'h0, 16'h0), 0);
		send_item(make_item(OP_UPDATE, 3'd0, 32'hFFFD_0000, 32'h0000_7FFF, 16'h1234), 0);
		send_item(make_item(OP_RESET_ONE, 3'd7, 32'h0, 32'h0, 16'h0), 0);
		send_item(make_item(OP_RESET_ONE, 3'd6, 32'h0, 32'h0, 16'h0), 0);
		send_item(make_item(OP_UPDATE, 3'd0, 32'hFFFC_0000, 32'h0000_0000, 16'h4000), 0);
		send_item(make_item(OP_STOP, 3'd0, 32'h0, 32'h0, 16'h0), 0);
		send_item(make_item(OP_UPDATE, 3'd5, 32'h0001_0000, 32'h0000_0000, 16'hFFFF), 1);
		send_item(make_item(OP_RESET_ALL, 3'd0, 32'h0, 32'h0, 16'h0), 0);
		send_item(make_item(OP_UPDATE, 3'd1, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555), 0);
		send_item(make_item(OP_UPDATE, 3'd1, 32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA), 0);
		// halfway ties in the position step, one each sign
		send_item(make_item(OP_UPDATE, 3'd2, 32'hFFFF_FFFF, 32'h0000_0001, 16'h0001), 0);
		send_item(make_item(OP_UPDATE, 3'd2, 32'h0000_0000, 32'hFFFF_FFFF, 16'h8000), 0);
		send_item(make_item(OP_UPDATE, 3'd2, 32'h0000_0000, 32'h0000_0000, 16'h8000), 0);
		send_item(make_item(OP_UPDATE, 3'd3, 32'h0000_0000, 32'h0000_0000, 16'h0000), 0);
		send_item(make_item(OP_UPDATE, 3'd3, 32'h0000_0000, 32'h0000_0000, 16'h0000), 0);
	endtask

	// result side: random stalls, plus one long hold on request
	initial begin
		int n;
		bit v;
		result_stall = 1'b0;
		forever begin
			if (hold_results) begin
				v = 1'b1;
				n = HOLD_CYCLES;
				hold_results = 1'b0;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin v = 1'b0; n = $urandom_range(1, 8); end
					4, 5, 6, 7: begin v = 1'b1; n = $urandom_range(1, 3); end
					8: begin v = 1'b1; n = $urandom_range(15, 40); end
					default: begin v = 1'b0; n = $urandom_range(40, 100); end
				endcase
			end
			repeat (n) begin
				@(negedge clk);
				result_stall <= v;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) sb.check_result(result);
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_results = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();

		for (int p = 0; p < 6; p++) begin
			idle_input();
			wait_drained();
			configure(p);
			repeat ((p == 2) ? 40 : 160) send_item(rand_item(), next_gap());
			if (p == 5) begin
				// back up the block against a held output, then drain fully
				idle_input();
				hold_results = 1'b1;
				wait (!hold_results);
				repeat (40) send_item(rand_item(), 0);
				idle_input();
				wait_drained();
				repeat (40) send_item(rand_item(), next_gap());
			end
		end

		idle_input();
		wait_drained();
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### multi_axis_velocity_controller_unit.f
+incdir+design
design/mavc_pkg.sv
design/mavc_cfg.sv
design/mavc_ctrl.sv
design/mavc_dp.sv
design/multi_axis_velocity_controller_unit.sv
tb/tb_multi_axis_velocity_controller_unit.sv
